### hdl/sbs_pkg.sv
// Shared types and constants for the scan breakpoint segmenter.
package sbs_pkg;

    localparam int COORD_W = 16;
    localparam int INDEX_W = 12;
    localparam int COUNT_W = 13;
    localparam int GAP_W   = 17;
    localparam int SQ_W    = 32;
    localparam int D2_W    = 33;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MEMBERS = 2'd1;

    localparam logic [COORD_W-1:0] MAX_GAP_RESET     = 16'd200;
    localparam logic [COUNT_W-1:0] MIN_MEMBERS_RESET = 13'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_SQUARE,
        S_COMPARE,
        S_ROOT,
        S_UPDATE,
        S_EMIT_A,
        S_EMIT_B
    } t_state;

    typedef struct packed {
        logic load;
        logic diff;
        logic square;
        logic root_start;
        logic update;
        logic load_a;
        logic load_b;
    } t_cmd;

    typedef struct packed {
        logic brk;
        logic root_busy;
        logic a_pend;
        logic last;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [INDEX_W-1:0] first_index;
        logic [INDEX_W-1:0] final_index;
        logic [COUNT_W-1:0] member_total;
        logic [GAP_W-1:0]   gap_before_mm;
        logic [GAP_W-1:0]   gap_after_mm;
        logic               size_ok;
        logic               scan_done;
    } t_result;

endpackage

### hdl/sbs_isqrt.sv
// Iterative floor square root, one result bit per cycle.
module sbs_isqrt
    import sbs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [D2_W-1:0]     i_value,
    output logic                o_busy,
    output logic [GAP_W-1:0]    o_root
);

    localparam int STEPS = GAP_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [D2_W-1:0]  r_rem, n_rem;
    logic [D2_W:0]    r_res, n_res;
    logic [D2_W-1:0]  r_bit, n_bit;
    logic [D2_W:0]    w_trial;

    assign w_trial = r_res + {1'b0, r_bit};

    always_comb begin
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_res = r_res;
        n_bit = r_bit;
        if (i_start) begin
            n_cnt = CNT_W'(STEPS);
            n_rem = i_value;
            n_res = '0;
            n_bit = {1'b1, {(D2_W-1){1'b0}}};
        end else if (r_cnt != '0) begin
            if ({1'b0, r_rem} >= w_trial) begin
                n_rem = r_rem - w_trial[D2_W-1:0];
                n_res = (r_res >> 1) + {1'b0, r_bit};
            end else begin
                n_res = r_res >> 1;
            end
            n_bit = r_bit >> 2;
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    assign o_busy = (r_cnt != '0);
    assign o_root = r_res[GAP_W-1:0];

endmodule

### hdl/sbs_ctrl.sv
// Sequencing state machine for the segmenter.
module sbs_ctrl
    import sbs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_SQUARE;
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_COMPARE;
            end
            S_COMPARE: begin
                if (i_sts.brk) begin
                    o_cmd.root_start = 1'b1;
                    n_state          = S_ROOT;
                end else begin
                    n_state = S_UPDATE;
                end
            end
            S_ROOT: begin
                if (!i_sts.root_busy) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_EMIT_A;
            end
            S_EMIT_A: begin
                // a_pend and last are settled by the update cycle
                if (!i_sts.a_pend) begin
                    n_state = i_sts.last ? S_EMIT_B : S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.load_a = 1'b1;
                    n_state      = i_sts.last ? S_EMIT_B : S_IDLE;
                end
            end
            S_EMIT_B: begin
                if (i_sts.out_free) begin
                    o_cmd.load_b = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/sbs_datapath.sv
// Distance, threshold, cluster bookkeeping and output register.
module sbs_datapath
    import sbs_pkg::*;
#(
    parameter int MAX_POINTS = 4096
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic signed [COORD_W-1:0] i_x_mm,
    input  logic signed [COORD_W-1:0] i_y_mm,
    input  logic                    i_last_point,
    input  logic                    i_ready,
    output logic                    o_valid,
    output t_result                 o_result
);

    localparam int CW      = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int RUN_CAP = (MAX_POINTS > 8191) ? 8191 : MAX_POINTS;

    // configuration
    logic [COORD_W-1:0] r_max_gap;
    logic [COUNT_W-1:0] r_min;

    // scan state
    logic signed [COORD_W-1:0] r_prev_x, r_prev_y;
    logic                      r_have_prev;
    logic [CW-1:0]             r_idx;
    logic [CW-1:0]             r_begin;
    logic [COUNT_W-1:0]        r_run;
    logic [GAP_W-1:0]          r_lead;

    // per-point working registers
    logic signed [COORD_W-1:0] r_x, r_y;
    logic                      r_last;
    logic signed [COORD_W:0]   r_dx, r_dy;
    logic [SQ_W-1:0]           r_sqx, r_sqy, r_t2;
    logic                      r_brk;
    logic                      r_a_pend;
    t_result                   r_res_a, r_res_b;

    t_result                   r_out;
    logic                      r_out_valid;

    logic signed [2*COORD_W+1:0] w_px, w_py;
    logic [2*COORD_W-1:0]      w_pt;
    logic [D2_W-1:0]           w_d2;
    logic                      w_brk;
    logic                      w_root_busy;
    logic [GAP_W-1:0]          w_root;
    logic [GAP_W-1:0]          w_gap;
    logic [CW-1:0]             w_prev_idx, w_next_idx;
    logic                      w_restart;
    logic [COUNT_W-1:0]        w_base_run, w_new_run;
    logic [CW-1:0]             w_new_begin;
    logic [GAP_W-1:0]          w_new_lead;
    logic                      w_out_free;

    assign w_px = r_dx * r_dx;
    assign w_py = r_dy * r_dy;
    assign w_pt = r_max_gap * r_max_gap;

    assign w_d2  = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign w_brk = r_have_prev && (w_d2 >= {1'b0, r_t2});

    sbs_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.root_start),
        .i_value (w_d2),
        .o_busy  (w_root_busy),
        .o_root  (w_root)
    );

    assign w_gap = r_brk ? w_root : '0;

    assign w_prev_idx = (r_idx == '0) ? CW'(MAX_POINTS - 1) : r_idx - 1'b1;
    assign w_next_idx = (r_idx == CW'(MAX_POINTS - 1)) ? '0 : r_idx + 1'b1;

    assign w_restart   = !r_have_prev || r_brk;
    assign w_base_run  = w_restart ? '0 : r_run;
    assign w_new_run   = (w_base_run < COUNT_W'(RUN_CAP)) ? w_base_run + 1'b1 : w_base_run;
    assign w_new_begin = w_restart ? r_idx : r_begin;
    assign w_new_lead  = !r_have_prev ? '0 : (r_brk ? w_gap : r_lead);

    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_gap <= MAX_GAP_RESET;
            r_min     <= MIN_MEMBERS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_GAP:     r_max_gap <= i_cfg_data;
                CFG_MIN_MEMBERS: r_min     <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have_prev <= 1'b0;
            r_idx       <= '0;
            r_begin     <= '0;
            r_run       <= '0;
            r_lead      <= '0;
            r_a_pend    <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_last <= i_last_point;
            end
            if (i_cmd.update) begin
                r_a_pend <= r_brk && (r_run >= r_min);
                if (r_last) begin
                    r_prev_x    <= '0;
                    r_prev_y    <= '0;
                    r_have_prev <= 1'b0;
                    r_idx       <= '0;
                    r_begin     <= '0;
                    r_run       <= '0;
                    r_lead      <= '0;
                end else begin
                    r_prev_x    <= r_x;
                    r_prev_y    <= r_y;
                    r_have_prev <= 1'b1;
                    r_idx       <= w_next_idx;
                    r_begin     <= w_new_begin;
                    r_run       <= w_new_run;
                    r_lead      <= w_new_lead;
                end
            end
            if (i_cmd.load_a || i_cmd.load_b) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_x_mm;
            r_y <= i_y_mm;
        end
        if (i_cmd.diff) begin
            r_dx <= {r_x[COORD_W-1], r_x} - {r_prev_x[COORD_W-1], r_prev_x};
            r_dy <= {r_y[COORD_W-1], r_y} - {r_prev_y[COORD_W-1], r_prev_y};
        end
        if (i_cmd.square) begin
            r_sqx <= w_px[SQ_W-1:0];
            r_sqy <= w_py[SQ_W-1:0];
            r_t2  <= w_pt;
        end
        if (i_cmd.root_start || i_cmd.load) begin
            r_brk <= i_cmd.root_start;
        end
        if (i_cmd.update) begin
            r_res_a.first_index   <= INDEX_W'(r_begin);
            r_res_a.final_index   <= INDEX_W'(w_prev_idx);
            r_res_a.member_total  <= r_run;
            r_res_a.gap_before_mm <= r_lead;
            r_res_a.gap_after_mm  <= w_gap;
            r_res_a.size_ok       <= 1'b1;
            r_res_a.scan_done     <= 1'b0;
            r_res_b.first_index   <= INDEX_W'(w_new_begin);
            r_res_b.final_index   <= INDEX_W'(r_idx);
            r_res_b.member_total  <= w_new_run;
            r_res_b.gap_before_mm <= w_new_lead;
            r_res_b.gap_after_mm  <= '0;
            r_res_b.size_ok       <= (w_new_run >= r_min);
            r_res_b.scan_done     <= 1'b1;
        end
        if (i_cmd.load_a) begin
            r_out <= r_res_a;
        end else if (i_cmd.load_b) begin
            r_out <= r_res_b;
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.brk       = w_brk;
        o_sts.root_busy = w_root_busy;
        o_sts.a_pend    = r_a_pend;
        o_sts.last      = r_last;
        o_sts.out_free  = w_out_free;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // datapath checks
    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load_a && i_cmd.load_b))
        else $error("both pending results loaded in one cycle");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_a || i_cmd.load_b) |-> w_out_free)
        else $error("result loaded over an untaken result");

    a_break_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_a |=> (r_out.size_ok && !r_out.scan_done))
        else $error("breakpoint result without size flag or with scan end");

    a_root_on_break: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.root_start |-> (w_brk && !w_root_busy))
        else $error("square root started without a breakpoint");

endmodule

### hdl/scan_breakpoint_segmenter_top.sv
// Top level of the scan breakpoint segmenter.
//
// Usage:
//  - Input channel (i_valid/o_ready): one scan point per transfer, x/y in
//    signed millimeters, i_last_point set on the scan's final point.
//  - Output channel (o_valid/i_ready): one transfer per reported cluster,
//    at most two per point (a breakpoint cluster first, then the final
//    cluster of the scan when the point is marked last).
//  - Config channel (i_cfg_valid/o_cfg_ready): index 0 = max_gap_mm,
//    index 1 = min_members; always ready, write only while idle.
// Timing: one point at a time. Without a breakpoint o_ready returns after the
// difference, square, compare, update and emit steps. A breakpoint adds the
// bit-serial square root (17 steps plus a finish step). A point marked last
// adds an emit step for the final cluster. A result shows on o_valid the
// cycle after its emit step.
// The output register decouples the sides: a new point can be taken while
// a result waits. If the receiver stalls, the block holds in its emit
// step until the register frees up.
// Reset (synchronous, active low) restores max_gap_mm=200, min_members=3, index 0.
module scan_breakpoint_segmenter_top
    import sbs_pkg::*;
#(
    parameter int MAX_POINTS = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [COORD_W-1:0]   i_x_mm,
    input  logic signed [COORD_W-1:0]   i_y_mm,
    input  logic                        i_last_point,

    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [INDEX_W-1:0]          o_first_index,
    output logic [INDEX_W-1:0]          o_final_index,
    output logic [COUNT_W-1:0]          o_member_total,
    output logic [GAP_W-1:0]            o_gap_before_mm,
    output logic [GAP_W-1:0]            o_gap_after_mm,
    output logic                        o_size_ok,
    output logic                        o_scan_done,

    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    t_cmd    w_cmd;
    t_sts    w_sts;
    t_result w_result;

    // config writes land directly in the registers, so the port never stalls
    assign o_cfg_ready = 1'b1;

    sbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    sbs_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_x_mm       (i_x_mm),
        .i_y_mm       (i_y_mm),
        .i_last_point (i_last_point),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_result     (w_result)
    );

    assign o_first_index   = w_result.first_index;
    assign o_final_index   = w_result.final_index;
    assign o_member_total  = w_result.member_total;
    assign o_gap_before_mm = w_result.gap_before_mm;
    assign o_gap_after_mm  = w_result.gap_after_mm;
    assign o_size_ok       = w_result.size_ok;
    assign o_scan_done     = w_result.scan_done;

endmodule

### tb/scan_breakpoint_segmenter_top_test.sv
// Self-checking testbench for the scan breakpoint segmenter: scans in, clusters checked.
`timescale 1ns / 1ps

module scan_breakpoint_segmenter_top_test;
    import sbs_pkg::*;

    // Tracks the scan state from every accepted point and holds the clusters
    // the block owes us, oldest first.
    class segment_tracker;
        logic [COORD_W-1:0]        gap_limit;
        logic [COUNT_W-1:0]        min_count;
        logic signed [COORD_W-1:0] last_x;
        logic signed [COORD_W-1:0] last_y;
        bit                        seen_prev;
        logic [INDEX_W-1:0]        next_index;
        logic [INDEX_W-1:0]        begin_index;
        logic [COUNT_W-1:0]        members;
        logic [GAP_W-1:0]          gap_in;
        t_result                   owed_clusters[$];
        int                        bad_fields;

        function new();
            gap_limit  = MAX_GAP_RESET;
            min_count  = MIN_MEMBERS_RESET;
            bad_fields = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            last_x      = '0;
            last_y      = '0;
            seen_prev   = 1'b0;
            next_index  = '0;
            begin_index = '0;
            members     = '0;
            gap_in      = '0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MAX_GAP:     gap_limit = data;
                CFG_MIN_MEMBERS: min_count = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // floor(sqrt(v)), one result bit at a time
        function logic [GAP_W-1:0] floor_sqrt(longint v);
            logic [GAP_W-1:0] root;
            logic [GAP_W-1:0] trial;
            root = '0;
            for (int b = GAP_W - 1; b >= 0; b--) begin
                trial = root | (GAP_W'(1) << b);
                if (longint'(trial) * longint'(trial) <= v)
                    root = trial;
            end
            return root;
        endfunction

        function void owe(logic [INDEX_W-1:0] first, logic [INDEX_W-1:0] fin,
                          logic [GAP_W-1:0] gap_out, bit ok, bit done);
            t_result r;
            r.first_index   = first;
            r.final_index   = fin;
            r.member_total  = members;
            r.gap_before_mm = gap_in;
            r.gap_after_mm  = gap_out;
            r.size_ok       = ok;
            r.scan_done     = done;
            owed_clusters.insert(owed_clusters.size(), r);
        endfunction

        function void take_point(logic signed [COORD_W-1:0] x,
                                 logic signed [COORD_W-1:0] y, bit last);
            longint           dx;
            longint           dy;
            longint           d2;
            longint           t2;
            logic [GAP_W-1:0] gap;
            if (seen_prev) begin
                dx = longint'(x) - longint'(last_x);
                dy = longint'(y) - longint'(last_y);
                d2 = dx * dx + dy * dy;
                t2 = longint'(gap_limit) * longint'(gap_limit);
                if (d2 >= t2) begin
                    // breakpoint: close the running cluster, report it if big enough
                    gap = floor_sqrt(d2);
                    if (members >= min_count)
                        owe(begin_index, next_index - 1'b1, gap, 1'b1, 1'b0);
                    begin_index = next_index;
                    members     = '0;
                    gap_in      = gap;
                end
            end else begin
                begin_index = next_index;
                members     = '0;
                gap_in      = '0;
            end
            if (members < COUNT_W'(4096))
                members++;
            if (last) begin
                owe(begin_index, next_index, '0, members >= min_count, 1'b1);
                clear_scan();
            end else begin
                last_x     = x;
                last_y     = y;
                seen_prev  = 1'b1;
                next_index = next_index + 1'b1;
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            bad_fields++;
        endtask

        task compare_field(string name, longint got, longint want);
            if (got != want)
                report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task match_cluster(t_result got);
            t_result want;
            if (owed_clusters.size() == 0) begin
                report_mismatch($sformatf("unexpected cluster %0d..%0d",
                                          got.first_index, got.final_index));
                return;
            end
            want = owed_clusters.pop_front();
            compare_field("first_index",   got.first_index,   want.first_index);
            compare_field("final_index",   got.final_index,   want.final_index);
            compare_field("member_total",  got.member_total,  want.member_total);
            compare_field("gap_before_mm", got.gap_before_mm, want.gap_before_mm);
            compare_field("gap_after_mm",  got.gap_after_mm,  want.gap_after_mm);
            compare_field("size_ok",       got.size_ok,       want.size_ok);
            compare_field("scan_done",     got.scan_done,     want.scan_done);
        endtask

        function int owed();
            return owed_clusters.size();
        endfunction
    endclass

    // Settle time before a register write: a point stays inside the block longest
    // when it is both a breakpoint and a last point, plus emit slack.
    localparam int SETTLE_CYCLES = 40;

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_valid      = 1'b0;
    logic                      o_ready;
    logic signed [COORD_W-1:0] i_x_mm       = '0;
    logic signed [COORD_W-1:0] i_y_mm       = '0;
    logic                      i_last_point = 1'b0;
    logic                      o_valid;
    logic                      i_ready      = 1'b0;
    logic [INDEX_W-1:0]        o_first_index;
    logic [INDEX_W-1:0]        o_final_index;
    logic [COUNT_W-1:0]        o_member_total;
    logic [GAP_W-1:0]          o_gap_before_mm;
    logic [GAP_W-1:0]          o_gap_after_mm;
    logic                      o_size_ok;
    logic                      o_scan_done;
    logic                      i_cfg_valid  = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data   = '0;

    segment_tracker tracker;

    int send_idle_pct   = 0;   // chance per cycle that the sender holds off
    int ready_stall_pct = 0;   // chance per cycle that the receiver stalls
    int hold_left       = 0;   // forced receiver hold-off, in cycles
    int gap_setting     = 200; // mirror of max_gap_mm, shapes the point walk

    scan_breakpoint_segmenter_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_x_mm          (i_x_mm),
        .i_y_mm          (i_y_mm),
        .i_last_point    (i_last_point),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_first_index   (o_first_index),
        .o_final_index   (o_final_index),
        .o_member_total  (o_member_total),
        .o_gap_before_mm (o_gap_before_mm),
        .o_gap_after_mm  (o_gap_after_mm),
        .o_size_ok       (o_size_ok),
        .o_scan_done     (o_scan_done),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Monitors sample at the edge, before any of this step's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            tracker.set_register(i_cfg_index, i_cfg_data);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            tracker.take_point(i_x_mm, i_y_mm, i_last_point);
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.first_index   = o_first_index;
            got.final_index   = o_final_index;
            got.member_total  = o_member_total;
            got.gap_before_mm = o_gap_before_mm;
            got.gap_after_mm  = o_gap_after_mm;
            got.size_ok       = o_size_ok;
            got.scan_done     = o_scan_done;
            tracker.match_cluster(got);
        end
    end

    // Receiver: a forced hold-off wins over the random stall pattern.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= ($urandom_range(99) >= ready_stall_pct);
            end
        end
    end

    // Offer one point and wait for its transfer. Valid stays high afterwards,
    // so back-to-back points never drop it; the next call or drop_valid decides.
    task automatic send_point(input int x, input int y, input bit last);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid      <= 1'b1;
        i_x_mm       <= x[COORD_W-1:0];
        i_y_mm       <= y[COORD_W-1:0];
        i_last_point <= last;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drop_valid();
        i_valid <= 1'b0;
    endtask

    // Wait until every owed cluster has arrived and the block has gone quiet.
    // The first edge lets the monitor book the point taken at the edge just passed.
    task automatic drain_clusters();
        @(posedge i_clk);
        while (tracker.owed() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Both registers in two back-to-back transfers; only legal while idle.
    task automatic program_limits(input int gap, input int min_pts);
        logic [COUNT_W-1:0] min_bits;
        min_bits     = min_pts[COUNT_W-1:0];
        gap_setting  = gap;
        i_cfg_valid  <= 1'b1;
        i_cfg_index  <= CFG_MAX_GAP;
        i_cfg_data   <= gap[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index  <= CFG_MIN_MEMBERS;
        i_cfg_data   <= CFG_DATA_W'(min_bits);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
    endtask

    task automatic program_random_limits();
        int gap;
        int min_pts;
        case ($urandom_range(5))
            0:       gap = 0;
            1:       gap = 65535;
            2:       gap = $urandom_range(20, 1);
            3:       gap = 200;
            4:       gap = $urandom_range(2000, 21);
            default: gap = $urandom_range(65534, 2001);
        endcase
        case ($urandom_range(4))
            0:       min_pts = 1;
            1:       min_pts = 4096;
            default: min_pts = $urandom_range(6, 1);
        endcase
        program_limits(gap, min_pts);
    endtask

    function automatic int clamp_coord(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int spread(int s);
        if (s <= 0)
            return 0;
        return int'($urandom_range(2 * s)) - s;
    endfunction

    // One scan as a walk: mostly steps inside the threshold, some exactly on
    // it or one below, some far jumps, and a few fully random points as noise.
    task automatic send_scan(input int len);
        int x;
        int y;
        int dx;
        int dy;
        int roll;
        int g;
        x = int'($urandom_range(65535)) - 32768;
        y = int'($urandom_range(65535)) - 32768;
        g = gap_setting;
        for (int i = 0; i < len; i++) begin
            if (i != 0) begin
                roll = $urandom_range(99);
                dx   = 0;
                dy   = 0;
                if (roll < 70) begin
                    dx = spread(g * 7 / 10);
                    dy = spread(g * 7 / 10);
                end else if (roll < 80) begin
                    dx = $urandom_range(1) ? g : -g;
                end else if (roll < 85) begin
                    dy = (g > 0) ? g - 1 : 0;
                end else if (roll < 95) begin
                    dx = $urandom_range(1) ? g + $urandom_range(2 * g + 10)
                                           : -g - int'($urandom_range(2 * g + 10));
                    dy = spread(g);
                end else begin
                    dx = int'($urandom_range(65535)) - 32768 - x;
                    dy = int'($urandom_range(65535)) - 32768 - y;
                end
                if ($urandom_range(1)) begin
                    roll = dx;
                    dx   = dy;
                    dy   = roll;
                end
                x = clamp_coord(x + dx);
                y = clamp_coord(y + dy);
            end
            send_point(x, y, i == len - 1);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_points);
        int sent;
        int len;
        int roll;
        send_idle_pct   = idle_pct;
        ready_stall_pct = stall_pct;
        program_random_limits();
        sent = 0;
        while (sent < n_points) begin
            if ($urandom_range(9) == 0) begin
                drop_valid();
                drain_clusters();
                program_random_limits();
            end
            roll = $urandom_range(99);
            if (roll < 20)
                len = 1;
            else if (roll < 80)
                len = $urandom_range(30, 2);
            else
                len = $urandom_range(120, 31);
            send_scan(len);
            sent += len;
        end
        drop_valid();
        drain_clusters();
    endtask

    initial begin
        tracker = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset limits: gap 200 mm, 3 members.
        // Single point scan at the coordinate extremes.
        send_point(-32768, 32767, 1'b1);
        // Break exactly at the threshold closes a 3-point cluster; one below
        // does not break; a 2-point cluster is dropped; the widest possible
        // gap; final cluster too small.
        send_point(0, 0, 1'b0);
        send_point(10, 0, 1'b0);
        send_point(20, 0, 1'b0);
        send_point(20, 200, 1'b0);
        send_point(20, 399, 1'b0);
        send_point(32767, -32768, 1'b0);
        send_point(-32768, 32767, 1'b0);
        send_point(-32767, 32767, 1'b1);
        // Last point is also a breakpoint: two clusters in one step.
        send_point(5, 5, 1'b0);
        send_point(6, 6, 1'b0);
        send_point(7, 7, 1'b0);
        send_point(1000, 1000, 1'b1);
        drop_valid();
        drain_clusters();

        // Zero threshold: even repeated points split.
        program_limits(0, 1);
        send_point(1, 1, 1'b0);
        send_point(1, 1, 1'b0);
        send_point(-1, -1, 1'b1);
        drop_valid();
        drain_clusters();

        // Widest threshold and a minimum at the run cap of 4096: corner to corner still breaks.
        program_limits(65535, 4096);
        send_point(-32768, -32768, 1'b0);
        send_point(32767, 32767, 1'b0);
        send_point(32767, -32768, 1'b1);
        drop_valid();
        drain_clusters();

        // Backpressure: receiver holds off while every point makes a cluster,
        // so the output register fills and the block stops taking points.
        program_limits(0, 1);
        hold_left = 300;
        for (int i = 0; i < 40; i++)
            send_point(int'($urandom_range(65535)) - 32768,
                       int'($urandom_range(65535)) - 32768, i == 39);
        drop_valid();
        drain_clusters();

        // Random part, one idling pattern per phase.
        run_phase(0, 0, 340);
        run_phase(68, 0, 340);
        run_phase(0, 68, 340);
        run_phase(12, 12, 340);

        if (tracker.bad_fields == 0 && tracker.owed() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #15000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
hdl/sbs_pkg.sv
hdl/sbs_isqrt.sv
hdl/sbs_ctrl.sv
hdl/sbs_datapath.sv
hdl/scan_breakpoint_segmenter_top.sv
tb/scan_breakpoint_segmenter_top_test.sv
